/* hw/rtl/gcp_pkg.sv */
// Shared types, constants and helper functions for the G-code line field parser.
`timescale 1ns / 1ps

package gcp_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int NUM_NAMES          = 10;
    localparam int NUM_FIELDS         = 6;
    localparam int NAME_MAX_CHARS     = 4;
    localparam int QUEUE_DEPTH        = 2;
    localparam int OUT_VALUE_BITS     = 32;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field selector codes, also the bit positions in the used mask.
    localparam logic [2:0] FLD_X    = 3'd0;
    localparam logic [2:0] FLD_Y    = 3'd1;
    localparam logic [2:0] FLD_Z    = 3'd2;
    localparam logic [2:0] FLD_E    = 3'd3;
    localparam logic [2:0] FLD_F    = 3'd4;
    localparam logic [2:0] FLD_S    = 3'd5;
    localparam logic [2:0] FLD_NONE = 3'd7;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;

    // Command names in index order, padded with zero bytes.
    localparam logic [7:0] NAME_CHARS [NUM_NAMES][NAME_MAX_CHARS] = '{
        '{"G", "1", 8'h00, 8'h00},
        '{"G", "2", "8", 8'h00},
        '{"G", "9", "0", 8'h00},
        '{"G", "9", "1", 8'h00},
        '{"G", "9", "2", 8'h00},
        '{"M", "1", "0", "4"},
        '{"M", "1", "0", "9"},
        '{"M", "1", "4", "0"},
        '{"M", "1", "9", "0"},
        '{"M", "1", "0", "6"}
    };
    localparam logic [2:0] NAME_LENGTHS [NUM_NAMES] = '{
        3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    typedef enum logic [1:0] {
        PH_AWAIT_NAME = 2'd0,
        PH_IN_NAME    = 2'd1,
        PH_BETWEEN    = 2'd2,
        PH_IN_FIELD   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [3:0]  command;
        logic [31:0] x_value;
        logic [31:0] y_value;
        logic [31:0] z_value;
        logic [31:0] e_value;
        logic [31:0] f_value;
        logic [31:0] s_value;
        logic [5:0]  used_mask;
    } t_out_word;

    // Classified character as it travels through the queue.
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_sign;
        logic       is_minus;
        logic       is_blank;
        logic [2:0] letter;
    } t_char_info;

    // Names that still agree with a character at a given name position.
    function automatic logic [NUM_NAMES-1:0] name_hits(logic [7:0] c, logic [2:0] pos);
        logic [NUM_NAMES-1:0] hits;
        hits = '0;
        for (int i = 0; i < NUM_NAMES; i++) begin
            if (pos < NAME_LENGTHS[i]) begin
                hits[i] = (NAME_CHARS[i][pos[1:0]] == c);
            end
        end
        return hits;
    endfunction

    // Names whose length equals the given length.
    function automatic logic [NUM_NAMES-1:0] name_length_hits(logic [2:0] len);
        logic [NUM_NAMES-1:0] hits;
        for (int i = 0; i < NUM_NAMES; i++) begin
            hits[i] = (NAME_LENGTHS[i] == len);
        end
        return hits;
    endfunction

endpackage

/* hw/rtl/gcp_front.sv */
// Front end: accepts input words and classifies each character.
`timescale 1ns / 1ps

module gcp_front (
    input  gcp_pkg::t_in_word   i_word,
    output gcp_pkg::t_char_info o_info
);

    logic [7:0] ch;
    logic [7:0] digit_offset;

    assign ch           = i_word.ch;
    assign digit_offset = ch - gcp_pkg::CH_ZERO;

    always_comb begin
        o_info.ch       = ch;
        o_info.line_end = i_word.line_end;
        o_info.is_space = (ch == gcp_pkg::CH_SPACE);
        o_info.is_digit = (ch >= gcp_pkg::CH_ZERO) && (ch <= gcp_pkg::CH_NINE);
        o_info.digit    = digit_offset[3:0];
        o_info.is_sign  = (ch == gcp_pkg::CH_PLUS) || (ch == gcp_pkg::CH_MINUS);
        o_info.is_minus = (ch == gcp_pkg::CH_MINUS);
        o_info.is_blank = (ch >= gcp_pkg::CH_TAB) && (ch <= gcp_pkg::CH_CR);
        unique case (ch)
            "X":     o_info.letter = gcp_pkg::FLD_X;
            "Y":     o_info.letter = gcp_pkg::FLD_Y;
            "Z":     o_info.letter = gcp_pkg::FLD_Z;
            "E":     o_info.letter = gcp_pkg::FLD_E;
            "F":     o_info.letter = gcp_pkg::FLD_F;
            "S":     o_info.letter = gcp_pkg::FLD_S;
            default: o_info.letter = gcp_pkg::FLD_NONE;
        endcase
    end

endmodule

/* hw/rtl/gcp_queue.sv */
// Short queue of classified characters between the front and back ends.
`timescale 1ns / 1ps

module gcp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gcp_pkg::t_char_info i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output gcp_pkg::t_char_info o_data
);

    localparam int DEPTH = gcp_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    gcp_pkg::t_char_info r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    function automatic logic [PW-1:0] ptr_next(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/gcp_back.sv */
// Back end: line parser state, number accumulation and the result register.
`timescale 1ns / 1ps

module gcp_back #(
    parameter int VALUE_BITS = gcp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  gcp_pkg::t_char_info i_info,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gcp_pkg::t_out_word  o_out_word
);

    localparam int VB = VALUE_BITS;
    localparam int NF = gcp_pkg::NUM_FIELDS;
    localparam int NN = gcp_pkg::NUM_NAMES;
    localparam logic [VB-1:0] HALF = {1'b1, {(VB-1){1'b0}}};

    gcp_pkg::t_phase   r_phase, n_phase;
    logic [NN-1:0]     r_mask, n_mask;
    logic [2:0]        r_name_len, n_name_len;
    logic [2:0]        r_letter, n_letter;
    logic              r_started, n_started;
    logic              r_negative, n_negative;
    logic [VB-1:0]     r_acc, n_acc;
    logic [VB-1:0]     r_values [NF];
    logic [VB-1:0]     n_values [NF];
    logic [NF-1:0]     r_present, n_present;
    logic              r_out_valid;
    gcp_pkg::t_out_word r_out, n_out;

    logic [VB+3:0]     acc_ext, prod;
    logic              sat;
    logic [VB-1:0]     acc_step;
    logic [VB-1:0]     value_step;
    logic              take_digit;
    logic [NN-1:0]     final_mask;
    logic              ok;
    logic [3:0]        cmd;
    logic [63:0]       ext [NF];
    logic [31:0]       vals [NF];

    // Line-end words wait for a free result register; other words never stall.
    assign o_pop       = i_valid && (!i_info.line_end || !r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Saturating accumulate by ten; saturation when the new magnitude exceeds half.
    always_comb begin
        acc_ext    = {4'b0, r_acc};
        prod       = (acc_ext << 3) + (acc_ext << 1) + {{VB{1'b0}}, i_info.digit};
        sat        = prod > {4'b0, HALF};
        acc_step   = sat ? HALF : prod[VB-1:0];
        if (n_negative) begin
            value_step = '0 - acc_step;
        end else begin
            value_step = (acc_step == HALF) ? HALF - 1'b1 : acc_step;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_mask     = r_mask;
        n_name_len = r_name_len;
        n_letter   = r_letter;
        n_started  = r_started;
        n_negative = r_negative;
        n_acc      = r_acc;
        n_values   = r_values;
        n_present  = r_present;
        take_digit = 1'b0;

        unique case (r_phase)
            gcp_pkg::PH_AWAIT_NAME, gcp_pkg::PH_IN_NAME: begin
                if (i_info.is_space) begin
                    if (r_phase == gcp_pkg::PH_IN_NAME) begin
                        n_mask  = r_mask & gcp_pkg::name_length_hits(r_name_len);
                        n_phase = gcp_pkg::PH_BETWEEN;
                    end
                end else begin
                    n_phase = gcp_pkg::PH_IN_NAME;
                    n_mask  = r_mask & gcp_pkg::name_hits(i_info.ch, r_name_len);
                    if (r_name_len != 3'd7) begin
                        n_name_len = r_name_len + 3'd1;
                    end
                end
            end
            gcp_pkg::PH_BETWEEN: begin
                if (!i_info.is_space) begin
                    n_phase    = gcp_pkg::PH_IN_FIELD;
                    n_letter   = i_info.letter;
                    n_started  = 1'b0;
                    n_negative = 1'b0;
                    n_acc      = '0;
                    if (i_info.letter != gcp_pkg::FLD_NONE) begin
                        n_present[i_info.letter] = 1'b1;
                        n_values[i_info.letter]  = '0;
                    end
                end
            end
            gcp_pkg::PH_IN_FIELD: begin
                if (i_info.is_space) begin
                    n_phase  = gcp_pkg::PH_BETWEEN;
                    n_letter = gcp_pkg::FLD_NONE;
                end else if (r_letter != gcp_pkg::FLD_NONE) begin
                    priority if (!r_started && i_info.is_blank) begin
                        n_letter = r_letter;
                    end else if (!r_started && i_info.is_sign) begin
                        n_started  = 1'b1;
                        n_negative = i_info.is_minus;
                    end else if (!i_info.is_digit) begin
                        n_letter = gcp_pkg::FLD_NONE;
                    end else begin
                        n_started  = 1'b1;
                        take_digit = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (take_digit) begin
            n_acc              = acc_step;
            n_values[r_letter] = value_step;
        end
    end

    // Result assembly on the line-end word.
    always_comb begin
        final_mask = (n_phase == gcp_pkg::PH_IN_NAME)
                   ? (n_mask & gcp_pkg::name_length_hits(n_name_len)) : n_mask;
        ok  = (n_phase != gcp_pkg::PH_AWAIT_NAME) && (final_mask != '0);
        cmd = '0;
        for (int i = NN - 1; i >= 0; i--) begin
            if (final_mask[i]) begin
                cmd = 4'(i);
            end
        end
        for (int k = 0; k < NF; k++) begin
            ext[k]  = 64'(signed'(n_values[k]));
            vals[k] = ok ? ext[k][31:0] : 32'd0;
        end
        n_out.status    = ok ? gcp_pkg::STATUS_OK : gcp_pkg::STATUS_UNKNOWN;
        n_out.command   = ok ? cmd : 4'd0;
        n_out.x_value   = vals[gcp_pkg::FLD_X];
        n_out.y_value   = vals[gcp_pkg::FLD_Y];
        n_out.z_value   = vals[gcp_pkg::FLD_Z];
        n_out.e_value   = vals[gcp_pkg::FLD_E];
        n_out.f_value   = vals[gcp_pkg::FLD_F];
        n_out.s_value   = vals[gcp_pkg::FLD_S];
        n_out.used_mask = ok ? n_present : 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= gcp_pkg::PH_AWAIT_NAME;
            r_mask      <= '1;
            r_name_len  <= '0;
            r_letter    <= gcp_pkg::FLD_NONE;
            r_started   <= 1'b0;
            r_negative  <= 1'b0;
            r_acc       <= '0;
            r_values    <= '{default: '0};
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_info.line_end) begin
                r_phase     <= gcp_pkg::PH_AWAIT_NAME;
                r_mask      <= '1;
                r_name_len  <= '0;
                r_letter    <= gcp_pkg::FLD_NONE;
                r_started   <= 1'b0;
                r_negative  <= 1'b0;
                r_acc       <= '0;
                r_values    <= '{default: '0};
                r_present   <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_pop) begin
                    r_phase    <= n_phase;
                    r_mask     <= n_mask;
                    r_name_len <= n_name_len;
                    r_letter   <= n_letter;
                    r_started  <= n_started;
                    r_negative <= n_negative;
                    r_acc      <= n_acc;
                    r_values   <= n_values;
                    r_present  <= n_present;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_info.line_end) begin
            r_out <= n_out;
        end
    end

endmodule

/* hw/rtl/gcode_line_field_parser.sv */
// Top level of the G-code line field parser: front end, queue and back end.
`timescale 1ns / 1ps

// The block takes a command line one character per word, the last character
// flagged by line_end, and delivers one result word per line carrying the
// status, the command index, the X, Y, Z, E, F and S values and a mask of the
// fields seen. It accepts one input word per clock cycle while the queue is
// not full. A word is classified by the front end as it is accepted and
// written into a two-entry queue; the back end takes one word a cycle from
// the queue, save a line-end word held back by an untaken result, and
// advances the parser with the single multiply-by-ten-and-add of the number
// accumulator. A result word is loaded into the output register at the same
// edge at which its line-end character leaves the queue. The output register
// lets the next line stream in while a result waits; only a second line-end
// word stalls behind an untaken result, and then the queue fills and input
// ready falls. Values accumulate in VALUE_BITS bits and saturate to that
// signed range before being presented as 32-bit words. No clearing pass is
// needed after reset; the block is ready as soon as reset is released.
module gcode_line_field_parser #(
    parameter int VALUE_BITS = gcp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gcp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gcp_pkg::t_out_word o_out_word
);

    gcp_pkg::t_char_info front_info;
    gcp_pkg::t_char_info queue_info;
    logic                queue_full;
    logic                queue_valid;
    logic                queue_pop;
    logic                queue_push;

    // Ready depends only on the queue fill, never on the output side.
    assign o_in_ready = !queue_full;
    assign queue_push = i_in_valid && !queue_full;

    gcp_front u_front (
        .i_word (i_in_word),
        .o_info (front_info)
    );

    gcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_data  (front_info),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_info)
    );

    gcp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_info      (queue_info),
        .o_pop       (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

/* verif/gcp_line_checker.sv */
// Checker for the G-code line field parser: predicts each result word and compares it.
`timescale 1ns / 1ps

module gcp_line_checker #(
    parameter int VALUE_BITS = gcp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  gcp_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  gcp_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    import gcp_pkg::*;

    typedef enum logic [3:0] {
        CMD_G1, CMD_G28, CMD_G90, CMD_G91, CMD_G92,
        CMD_M104, CMD_M109, CMD_M140, CMD_M190, CMD_M106
    } t_command;

    // Names right-aligned in 32 bits, matching how the name text is shifted in.
    localparam logic [31:0] CMD_TEXT [NUM_NAMES] = '{
        "G1", "G28", "G90", "G91", "G92", "M104", "M109", "M140", "M190", "M106"
    };
    localparam int CMD_CHARS [NUM_NAMES] = '{2, 3, 3, 3, 3, 4, 4, 4, 4, 4};
    localparam logic [63:0] MAG_LIMIT = 64'd1 << (VALUE_BITS - 1);

    t_phase                  phase;
    logic [2:0]              name_count;
    logic [31:0]             name_text;
    logic [2:0]              field_sel;
    logic                    num_started;
    logic                    num_negative;
    logic [VALUE_BITS-1:0]   magnitude;
    logic [31:0]             field_value [NUM_FIELDS];
    logic [NUM_FIELDS-1:0]   field_seen;
    t_out_word               expected_results [$];
    int                      mismatches = 0;

    task clear_line_state;
        phase        = PH_AWAIT_NAME;
        name_count   = '0;
        name_text    = '0;
        field_sel    = FLD_NONE;
        num_started  = 1'b0;
        num_negative = 1'b0;
        magnitude    = '0;
        field_seen   = '0;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            field_value[k] = '0;
        end
    endtask

    task take_name_char(input logic [7:0] c);
        if (name_count < 3'd4) begin
            name_text = {name_text[23:0], c};
        end
        if (name_count != 3'd7) begin
            name_count = name_count + 3'd1;
        end
    endtask

    // Number reading inside a field token, in the manner of atoi.
    task advance_number(input logic [7:0] c);
        logic        digit;
        logic [63:0] dval;
        logic [63:0] mag_wide;
        logic [63:0] signed_word;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (field_sel > FLD_S) begin
            return;
        end
        if (!num_started) begin
            if (c >= CH_TAB && c <= CH_CR) begin
                return;
            end
            if (c == CH_PLUS || c == CH_MINUS) begin
                num_started  = 1'b1;
                num_negative = (c == CH_MINUS);
                return;
            end
            num_started = 1'b1;
        end
        if (!digit) begin
            field_sel = FLD_NONE;
            return;
        end
        dval     = 64'(c - CH_ZERO);
        mag_wide = 64'(magnitude);
        if (mag_wide > (MAG_LIMIT - dval) / 64'd10) begin
            mag_wide = MAG_LIMIT;
        end else begin
            mag_wide = mag_wide * 64'd10 + dval;
        end
        magnitude = mag_wide[VALUE_BITS-1:0];
        if (num_negative) begin
            signed_word = 64'd0 - mag_wide;
        end else if (mag_wide >= MAG_LIMIT) begin
            signed_word = MAG_LIMIT - 64'd1;
        end else begin
            signed_word = mag_wide;
        end
        field_value[field_sel] = signed_word[31:0];
    endtask

    task close_line;
        t_out_word exp_word;
        logic      found;
        t_command  cmd;
        if (phase == PH_IN_NAME) begin
            phase = PH_BETWEEN;
        end
        found = 1'b0;
        cmd   = CMD_G1;
        for (int k = 0; k < NUM_NAMES; k++) begin
            if (name_count == 3'(CMD_CHARS[k]) && name_text == CMD_TEXT[k]) begin
                found = 1'b1;
                cmd   = t_command'(k);
            end
        end
        exp_word        = '0;
        exp_word.status = STATUS_UNKNOWN;
        if (phase != PH_AWAIT_NAME && found) begin
            exp_word.status    = STATUS_OK;
            exp_word.command   = cmd;
            exp_word.x_value   = field_value[FLD_X];
            exp_word.y_value   = field_value[FLD_Y];
            exp_word.z_value   = field_value[FLD_Z];
            exp_word.e_value   = field_value[FLD_E];
            exp_word.f_value   = field_value[FLD_F];
            exp_word.s_value   = field_value[FLD_S];
            exp_word.used_mask = field_seen;
        end
        expected_results.push_back(exp_word);
        clear_line_state();
    endtask

    task parse_char(input t_in_word w);
        logic [7:0] c;
        c = w.ch;
        case (phase)
            PH_AWAIT_NAME: begin
                if (c != CH_SPACE) begin
                    phase = PH_IN_NAME;
                    take_name_char(c);
                end
            end
            PH_IN_NAME: begin
                if (c == CH_SPACE) begin
                    phase = PH_BETWEEN;
                end else begin
                    take_name_char(c);
                end
            end
            PH_BETWEEN: begin
                if (c != CH_SPACE) begin
                    phase = PH_IN_FIELD;
                    case (c)
                        "X":     field_sel = FLD_X;
                        "Y":     field_sel = FLD_Y;
                        "Z":     field_sel = FLD_Z;
                        "E":     field_sel = FLD_E;
                        "F":     field_sel = FLD_F;
                        "S":     field_sel = FLD_S;
                        default: field_sel = FLD_NONE;
                    endcase
                    num_started  = 1'b0;
                    num_negative = 1'b0;
                    magnitude    = '0;
                    if (field_sel <= FLD_S) begin
                        field_seen[field_sel]  = 1'b1;
                        field_value[field_sel] = '0;
                    end
                end
            end
            default: begin
                if (c == CH_SPACE) begin
                    phase     = PH_BETWEEN;
                    field_sel = FLD_NONE;
                end else begin
                    advance_number(c);
                end
            end
        endcase
        if (w.line_end) begin
            close_line();
        end
    endtask

    task compare_field(input string label, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    task check_result(input t_out_word got);
        t_out_word want;
        if (expected_results.size() == 0) begin
            $display("%0t: result word with none expected, expected nothing, actual %h",
                     $time, got);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("command", 32'(want.command), 32'(got.command));
        compare_field("x_value", want.x_value, got.x_value);
        compare_field("y_value", want.y_value, got.y_value);
        compare_field("z_value", want.z_value, got.z_value);
        compare_field("e_value", want.e_value, got.e_value);
        compare_field("f_value", want.f_value, got.f_value);
        compare_field("s_value", want.s_value, got.s_value);
        compare_field("used_mask", 32'(want.used_mask), 32'(got.used_mask));
    endtask

    initial begin
        clear_line_state();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line_state();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_word);
            end
            if (i_in_valid && i_in_ready) begin
                parse_char(i_in_word);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

/* verif/tb_gcode_line_field_parser.sv */
// Testbench top for the G-code line field parser: clock, reset, line stimulus and verdict.
`timescale 1ns / 1ps

module tb_gcode_line_field_parser;
    import gcp_pkg::*;

    // The run stops here whatever happens; a correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int TARGET_CHARS    = 850;
    localparam int MIN_LINES       = 60;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 10;
    localparam int QUEUE_HIGH_MARK = 32;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;
    int        fail_count;
    int        results_pending;

    // Words waiting to be offered to the block, and the line being assembled.
    t_in_word   pending_chars [$];
    logic [7:0] line_text [$];

    string cmd_names [NUM_NAMES] = '{
        "G1", "G28", "G90", "G91", "G92", "M104", "M109", "M140", "M190", "M106"
    };
    string boundary_digits [5] = '{
        "2147483647", "2147483648", "2147483649", "99999999999", "0000000000012"
    };
    string field_letters = "XYZEFS";
    string other_letters = "ABCDGHIJKLMNOPQRTUVW";
    string lower_letters = "xyzefs";

    int burst_left   = 1;
    int gap_left     = 0;
    int hold_left    = 0;
    int rx_cycle     = 0;
    int cycle_count  = 0;
    int chars_queued = 0;
    int lines_queued = 0;
    bit hold_request = 1'b0;
    bit pause_done   = 1'b0;
    bit hold_done    = 1'b0;

    always #5 clk = ~clk;

    gcode_line_field_parser DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    gcp_line_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // Sender. Words go out in bursts of random length separated by random gaps;
    // a gap of zero and the occasional very long burst give stretches with no
    // idling at all. Once a word is offered it is held until the block takes it,
    // and the next word is loaded in the same step, so valid never drops
    // between back-to-back words.
    always @(posedge clk) begin : drive_chars
        logic     next_valid;
        t_in_word next_word;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            next_word  = in_word;
            if (in_valid && in_ready) begin
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_chars.size() != 0) begin
                    next_word  = pending_chars.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= next_valid;
            in_word  <= next_word;
        end
    end

    // Receiver. Its stall pattern rotates through always ready, coin-flip,
    // mostly stalled and a fixed periodic hiccup. A hold request from
    // the stimulus holds ready low for a long stretch counted here, so that
    // result words pile up and the block has to push back on its input.
    always @(posedge clk) begin : drive_ready
        logic ready_next;
        rx_cycle++;
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            case ((rx_cycle / 150) % 4)
                0:       ready_next = 1'b1;
                1:       ready_next = $urandom_range(0, 1);
                2:       ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = ((rx_cycle % 8) != 5);
            endcase
        end
        out_ready <= ready_next;
    end

    // Watchdog: a hung handshake or a result that never arrives ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task add_byte(input logic [7:0] b);
        line_text.push_back(b);
    endtask

    task add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            line_text.push_back(s[k]);
        end
    endtask

    task add_spaces(input int count);
        repeat (count) add_byte(CH_SPACE);
    endtask

    // Flags the last character of the assembled line and hands the line to the
    // sender. Throttling happens on the falling edge so the queue is never
    // touched in the same step as the sender pops from it.
    task queue_line;
        if (line_text.size() == 0) begin
            line_text.push_back(CH_SPACE);
        end
        while (pending_chars.size() > QUEUE_HIGH_MARK) @(negedge clk);
        foreach (line_text[k]) begin
            pending_chars.push_back(t_in_word'{ch: line_text[k],
                                               line_end: (k == line_text.size() - 1)});
        end
        chars_queued += line_text.size();
        lines_queued++;
        line_text.delete();
    endtask

    // Mostly a real command name; otherwise a near miss: one character
    // changed, lowercase, one character too many or one too few.
    task add_name;
        string s;
        int    pick;
        s    = cmd_names[$urandom_range(0, NUM_NAMES - 1)];
        pick = $urandom_range(0, 11);
        if (pick == 8) begin
            s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(33, 126));
        end else if (pick == 9) begin
            s = s.tolower();
        end else if (pick == 10) begin
            s = {s, "0"};
        end else if (pick == 11) begin
            s = s.substr(0, s.len() - 2);
        end
        add_text(s);
    endtask

    // The part of a field token after its letter: optional whitespace, an
    // optional sign, then digits. Digit runs are usually short, sometimes long
    // enough to saturate, sometimes right on the 32-bit boundary, and now and
    // then missing; a stray character may end the number early.
    task add_number;
        int         pick;
        int         n_digits;
        logic [7:0] junk;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(CH_TAB, CH_CR)));
        end
        pick = $urandom_range(0, 5);
        if (pick == 0) begin
            add_byte(CH_PLUS);
        end else if (pick <= 2) begin
            add_byte(CH_MINUS);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            n_digits = 0;
        end else if (pick == 1) begin
            add_text(boundary_digits[$urandom_range(0, 4)]);
            n_digits = 0;
        end else if (pick <= 3) begin
            n_digits = $urandom_range(10, 14);
        end else begin
            n_digits = $urandom_range(1, 6);
        end
        repeat (n_digits) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) begin
            junk = 8'($urandom_range(0, 255));
            if (junk == CH_SPACE) begin
                junk = ".";
            end
            add_byte(junk);
        end
    endtask

    task add_field;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 7) begin
            add_byte(field_letters[$urandom_range(0, 5)]);
        end else if (pick == 8) begin
            add_byte(other_letters[$urandom_range(0, other_letters.len() - 1)]);
        end else begin
            add_byte(lower_letters[$urandom_range(0, 5)]);
        end
        add_number();
    endtask

    initial begin : stimulus
        logic [7:0] noise;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines: saturation both ways, sign with no digits, whitespace
        // before the number and a tab ending it, an empty line, an overlong
        // name, ignored tokens, a name ended by the line end, a repeated field
        // with a trailing space, byte zero and byte 0xFF.
        add_text("G1 X-9999999999 Y2147483647");
        queue_line();
        add_text("M106 S+");
        queue_line();
        add_text("G92 E");
        add_byte(CH_TAB);
        add_byte(CH_CR);
        add_text("-7");
        add_byte(CH_TAB);
        add_text("3");
        queue_line();
        add_byte(CH_SPACE);
        queue_line();
        add_text("G280 X1");
        queue_line();
        add_text("G1 x5 Q3 F");
        queue_line();
        add_text("G90");
        queue_line();
        add_text("M104 S1  S2 ");
        queue_line();
        add_byte(8'h00);
        queue_line();
        add_text("M140 Z2147483648 E-2147483649 X5");
        add_byte(8'hFF);
        queue_line();
        add_text("M109");
        add_byte(8'h00);
        add_text(" X1");
        queue_line();

        // Random lines. Nine in ten are well formed in shape with random
        // content; the rest are raw noise bytes with the odd space.
        while (chars_queued < TARGET_CHARS || lines_queued < MIN_LINES) begin
            if (!pause_done && chars_queued > 250) begin
                // Stop offering words until every result has been taken.
                while (pending_chars.size() != 0 || in_valid || results_pending != 0) begin
                    @(negedge clk);
                end
                pause_done = 1'b1;
            end
            if (!hold_done && chars_queued > 500) begin
                // Long receiver stall with short lines behind it, so several line
                // ends queue up and the block has to refuse further words.
                hold_request = 1'b1;
                hold_done    = 1'b1;
                repeat (6) begin
                    add_text("G1 X1");
                    queue_line();
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 10)) begin
                    noise = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 4) == 0) begin
                        noise = CH_SPACE;
                    end
                    add_byte(noise);
                end
            end else begin
                if ($urandom_range(0, 5) == 0) begin
                    add_spaces($urandom_range(1, 3));
                end
                add_name();
                repeat ($urandom_range(0, 5)) begin
                    add_spaces(($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
                    add_field();
                end
                if ($urandom_range(0, 4) == 0) begin
                    add_spaces($urandom_range(1, 2));
                end
            end
            queue_line();
        end

        // Everything offered and taken, then every expected result collected;
        // a final drain wait catches any result word that should not be there.
        while (pending_chars.size() != 0 || in_valid) @(negedge clk);
        while (results_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
